[rtl/core/dps_pkg.sv]
// Shared constants, types and build-time sine/gain tables for the 1D sine-transform Poisson solver.
// No dependencies.
package dps_pkg;

  localparam int POINTS_DEF = 32;
  localparam int POINTS_MAX = 64;
  localparam int SINE_MAX   = 2 * (POINTS_MAX + 1);

  localparam int SAMPLE_W = 24;
  localparam int RESULT_W = 32;
  localparam int SCALE_W  = 32;
  localparam int PADDR_W  = 3;
  localparam int SINE_W   = 32;
  localparam int GAIN_W   = 32;
  localparam int AMAG_W   = 31;
  localparam int VMAG_W   = 43;
  localparam int ACC_W    = 64;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd16777216;
  localparam logic [PADDR_W-1:0] REG_GRID_SCALE = 3'd0;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_MAX];
  typedef logic [GAIN_W-1:0] gain_rom_t [POINTS_MAX];

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
  } solve_cmd_t;

  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint signed sine_q30(longint unsigned m_in, longint unsigned d);
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned dv;
    longint signed acc;
    logic neg;
    m = m_in - udiv(m_in, 2 * d) * (2 * d);
    neg = 1'b0;
    if (m >= d) begin
      m = m - d;
      neg = 1'b1;
    end
    if (2 * m > d) m = d - m;
    x = udiv(PI_Q30 * m + (d >> 1), d);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    mag = x;
    acc = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      dv = longint'(2 * n) * longint'(2 * n + 1);
      mag = (mag * x2 + (64'd1 << 29)) >> 30;
      mag = udiv(mag + (dv >> 1), dv);
      if ((n & 1) == 1) acc = acc - longint'(mag);
      else acc = acc + longint'(mag);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return neg ? -acc : acc;
  endfunction

  function automatic sine_rom_t build_sine(int points);
    sine_rom_t rom;
    for (int m = 0; m < SINE_MAX; m++) begin
      if (m < 2 * (points + 1)) rom[m] = SINE_W'(sine_q30(longint'(m), longint'(points + 1)));
      else rom[m] = '0;
    end
    return rom;
  endfunction

  function automatic gain_rom_t build_gain(int points);
    gain_rom_t rom;
    longint unsigned s;
    longint unsigned s2;
    longint unsigned den;
    longint unsigned g;
    for (int k = 1; k <= POINTS_MAX; k++) begin
      rom[k-1] = '0;
      if (k <= points) begin
        s = longint'(sine_q30(longint'(k), longint'(2 * (points + 1))));
        s2 = (s * s + (64'd1 << 27)) >> 28;
        den = longint'(2 * (points + 1)) * s2;
        g = (den != 0) ? udiv((64'd1 << 60) + (den >> 1), den) : 64'hFFFF_FFFF;
        rom[k-1] = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
      end
    end
    return rom;
  endfunction

endpackage

[rtl/core/dps_front.sv]
// Front end: takes charge samples into the charge buffer and issues a solve request on the last one.
// Depends on dps_pkg.
module dps_front #(
  parameter int POINTS = dps_pkg::POINTS_DEF,
  localparam int IDX_W = $clog2(POINTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [dps_pkg::SAMPLE_W-1:0] charge_sample,
  input  logic [dps_pkg::SCALE_W-1:0]         grid_scale,
  output logic                                push,
  output dps_pkg::solve_cmd_t                 cmd,
  input  logic [IDX_W-1:0]                    rd_addr,
  output logic signed [dps_pkg::SAMPLE_W-1:0] rd_data
);
  import dps_pkg::*;

  logic signed [SAMPLE_W-1:0] charge_buffer [POINTS];
  logic [IDX_W-1:0] loaded_count;
  logic is_last;

  assign is_last = (loaded_count == IDX_W'(POINTS - 1));
  assign push = accept && is_last;
  assign cmd.scale = grid_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
    end else if (accept) begin
      loaded_count <= is_last ? '0 : loaded_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) charge_buffer[loaded_count] <= charge_sample;
    rd_data <= charge_buffer[rd_addr];
  end

endmodule

[rtl/core/dps_cmd_queue.sv]
// Two-entry request queue between the front end and the solve engine.
// Depends on dps_pkg.
module dps_cmd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dps_pkg::solve_cmd_t cmd_in,
  input  logic                pop,
  output logic                valid,
  output dps_pkg::solve_cmd_t cmd_out
);
  import dps_pkg::*;

  solve_cmd_t entry [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign valid = (count != 2'd0);
  assign cmd_out = entry[rd_ptr];
  assign do_push = push && (count != 2'd2);
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= cmd_in;
  end

endmodule

[rtl/core/dps_back.sv]
// Solve engine: forward sine transform, mode weighting, inverse transform on one shared MAC pipe.
// Depends on dps_pkg; reads the charge buffer held in dps_front.
module dps_back #(
  parameter int POINTS = dps_pkg::POINTS_DEF,
  localparam int IDX_W = $clog2(POINTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  dps_pkg::solve_cmd_t                 q_cmd,
  output logic                                q_pop,
  output logic [IDX_W-1:0]                    rd_addr,
  input  logic signed [dps_pkg::SAMPLE_W-1:0] rd_data,
  output logic                                active,
  output logic                                result_strobe,
  output logic signed [dps_pkg::RESULT_W-1:0] potential_sample,
  output logic                                last_point
);
  import dps_pkg::*;

  localparam int SIDX_W = $clog2(2 * (POINTS + 1));
  localparam logic [SIDX_W:0] TWO_N = (SIDX_W + 1)'(2 * (POINTS + 1));
  localparam sine_rom_t SINE = build_sine(POINTS);
  localparam gain_rom_t GAIN = build_gain(POINTS);
  localparam logic signed [ACC_W-1:0] HALF30 = 64'sh2000_0000;
  localparam logic signed [ACC_W-1:0] Y_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] Y_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_DRAIN, S_A, S_F, S_M, S_V, S_T, S_Y
  } state_t;

  state_t state;
  logic inv;
  logic [IDX_W-1:0] ic;
  logic [IDX_W-1:0] oc;
  logic [SIDX_W-1:0] idx;
  logic [SIDX_W-1:0] step;
  logic [SCALE_W-1:0] scale;

  logic [VMAG_W:0] spectral_buffer [POINTS];
  logic [VMAG_W:0] spec_rd;
  logic signed [SINE_W-1:0] s0;
  logic v0;
  logic v1;
  logic signed [51:0] ph;
  logic signed [56:0] pl;
  logic signed [ACC_W-1:0] acc_hi;
  logic signed [ACC_W-1:0] acc_lo;

  logic a_neg;
  logic [AMAG_W-1:0] a_mag;
  logic [63:0] gs;
  logic [35:0] factor;
  logic [AMAG_W+11:0] m_hi;
  logic [AMAG_W+23:0] m_lo;
  logic signed [ACC_W-1:0] q;
  logic signed [ACC_W-1:0] t;

  logic [SIDX_W:0] idx_sum;
  logic signed [SINE_W-1:0] s_eff;
  logic signed [19:0] op_hi;
  logic signed [24:0] op_lo;
  logic signed [ACC_W-1:0] a_full;
  logic signed [ACC_W-1:0] a_abs;
  logic [63:0] f_sum;
  logic [55:0] lo_r;
  logic [VMAG_W:0] v_sum;
  logic signed [ACC_W-1:0] t_sum;
  logic signed [ACC_W-1:0] y;
  logic o_last;
  logic [IDX_W-1:0] oc_next;
  logic [SIDX_W-1:0] step_next;

  assign active = (state != S_IDLE);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign rd_addr = ic;
  assign o_last = (oc == IDX_W'(POINTS - 1));
  assign oc_next = o_last ? '0 : oc + 1'b1;
  assign step_next = SIDX_W'(oc_next) + 1'b1;

  always_comb begin
    idx_sum = {1'b0, idx} + {1'b0, step};
    if (idx_sum >= TWO_N) idx_sum = idx_sum - TWO_N;
    if (inv) begin
      op_hi = $signed({1'b0, spec_rd[VMAG_W-1:24]});
      op_lo = $signed({1'b0, spec_rd[23:0]});
      s_eff = spec_rd[VMAG_W] ? -s0 : s0;
    end else begin
      op_hi = '0;
      op_lo = 25'(rd_data);
      s_eff = s0;
    end
    a_full = (acc_lo + HALF30) >>> 30;
    a_abs = a_full[ACC_W-1] ? -a_full : a_full;
    f_sum = gs + 64'h0800_0000;
    lo_r = {1'b0, m_lo} + 56'h80_0000;
    v_sum = (VMAG_W + 1)'(m_hi) + (VMAG_W + 1)'(lo_r[55:24]);
    t_sum = $signed({34'd0, acc_hi[5:0], 24'd0}) + acc_lo + HALF30;
    y = q + t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      inv <= 1'b0;
      ic <= '0;
      oc <= '0;
      idx <= '0;
      step <= '0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      result_strobe <= 1'b0;
      last_point <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      v0 <= 1'b0;
      v1 <= v0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            scale <= q_cmd.scale;
            inv <= 1'b0;
            oc <= '0;
            ic <= '0;
            idx <= SIDX_W'(1);
            step <= SIDX_W'(1);
            acc_hi <= '0;
            acc_lo <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          v0 <= 1'b1;
          idx <= idx_sum[SIDX_W-1:0];
          if (ic == IDX_W'(POINTS - 1)) begin
            state <= S_DRAIN;
          end else begin
            ic <= ic + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!v0 && !v1) state <= inv ? S_T : S_A;
        end
        S_A: begin
          a_neg <= a_full[ACC_W-1];
          a_mag <= a_abs[AMAG_W-1:0];
          gs <= GAIN[oc] * scale;
          state <= S_F;
        end
        S_F: begin
          factor <= f_sum[63:28];
          state <= S_M;
        end
        S_M: begin
          m_hi <= a_mag * factor[35:24];
          m_lo <= a_mag * factor[23:0];
          state <= S_V;
        end
        S_V: begin
          if (o_last) inv <= 1'b1;
          oc <= oc_next;
          ic <= '0;
          idx <= step_next;
          step <= step_next;
          acc_hi <= '0;
          acc_lo <= '0;
          state <= S_ISSUE;
        end
        S_T: begin
          q <= acc_hi >>> 6;
          t <= t_sum >>> 30;
          state <= S_Y;
        end
        S_Y: begin
          result_strobe <= 1'b1;
          last_point <= o_last;
          if (y > Y_MAX) potential_sample <= Y_MAX[RESULT_W-1:0];
          else if (y < Y_MIN) potential_sample <= Y_MIN[RESULT_W-1:0];
          else potential_sample <= y[RESULT_W-1:0];
          oc <= oc_next;
          ic <= '0;
          idx <= step_next;
          step <= step_next;
          acc_hi <= '0;
          acc_lo <= '0;
          state <= o_last ? S_IDLE : S_ISSUE;
        end
        default: state <= S_IDLE;
      endcase
      if (v1) begin
        acc_hi <= acc_hi + ACC_W'(ph);
        acc_lo <= acc_lo + ACC_W'(pl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_V) spectral_buffer[oc] <= {a_neg, v_sum[VMAG_W-1:0]};
    spec_rd <= spectral_buffer[ic];
    s0 <= SINE[idx];
    if (v0) begin
      ph <= op_hi * s_eff;
      pl <= op_lo * s_eff;
    end
  end

endmodule

[rtl/core/dst_poisson_solver_1d.sv]
// Top level of the 1D Dirichlet Poisson solver: APB register, front end, request queue, solve engine.
// Depends on dps_pkg, dps_front, dps_cmd_queue, dps_back.
//
// Usage: drive charge_sample with start high; a sample is taken at a clock edge where start
// is high and busy is low. Samples fill grid points 0..POINTS-1 in order. The last sample
// queues a solve and busy rises until the solve is done; no sample is taken meanwhile.
// The solve runs two POINTS x POINTS sine products on one multiply-accumulate pipe, one
// product term per cycle while a row is issued, plus per-row finishing steps between rows.
// Results leave one per row, each on potential_sample for a single cycle marked by
// result_strobe, last_point high on the final grid point. The receiver cannot stall.
// grid_scale (unsigned Q8.24) sits at byte address 0 of the APB port and is captured with the
// last sample of a grid, which queues the solve; write it only while busy is low.
// Reset (rst, synchronous) clears the sample count, the queue and the engine and sets
// grid_scale to 1.0. Buffers hold no reset value and are written before they are read.
module dst_poisson_solver_1d #(
  parameter int POINTS = dps_pkg::POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dps_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dps_pkg::SAMPLE_W-1:0] charge_sample,
  output logic                                result_strobe,
  output logic signed [dps_pkg::RESULT_W-1:0] potential_sample,
  output logic                                last_point
);
  import dps_pkg::*;

  localparam int IDX_W = $clog2(POINTS);

  logic [SCALE_W-1:0] grid_scale;
  logic reg_hit;
  logic accept;
  logic push;
  solve_cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  solve_cmd_t q_cmd;
  logic [IDX_W-1:0] rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic back_active;

  assign pready = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_GRID_SCALE[PADDR_W-1]);
  assign prdata = reg_hit ? grid_scale : 32'd0;
  assign busy = q_valid || back_active;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      grid_scale <= pwdata;
    end
  end

  dps_front #(.POINTS(POINTS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .charge_sample(charge_sample),
    .grid_scale(grid_scale), .push(push), .cmd(push_cmd),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  dps_cmd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .cmd_in(push_cmd),
    .pop(q_pop), .valid(q_valid), .cmd_out(q_cmd)
  );

  dps_back #(.POINTS(POINTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .rd_addr(rd_addr), .rd_data(rd_data), .active(back_active),
    .result_strobe(result_strobe), .potential_sample(potential_sample),
    .last_point(last_point)
  );

endmodule

[rtl/core/dps_checker.sv]
// Port-level checks for dst_poisson_solver_1d, attached by bind.
// Depends on dst_poisson_solver_1d.
module dps_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_strobe,
  input logic last_point
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !result_strobe)
    else $error("block not idle after reset");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_point |-> busy)
    else $error("result while not solving");

  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("results back to back");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_point |=> !result_strobe && !busy)
    else $error("solve still running after last point");

endmodule

bind dst_poisson_solver_1d dps_checker u_checker (.*);
